// ----- rtl/mbe_pkg.sv -----
`default_nettype none

package mbe_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_MIN_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_MAX_X      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_MIN_Y      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_MAX_Y      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 3'd6;

  localparam int LIMIT_BITS = 16;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd256;
  localparam int SIZE_RESET = 1024;
  localparam int SIZE_RESET_BITS = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP_MUL,
    ST_MAP_FIN,
    ST_IT_MUL,
    ST_IT_UPD,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic map_sel;
    logic map_fin;
    logic iter;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic limit_zero;
    logic escape;
    logic at_limit;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/mbe_regs.sv -----
`default_nettype none

module mbe_regs #(
  parameter int CB  = 12,
  parameter int FB  = 32,
  parameter int SZB = 13
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [mbe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [FB-1:0]                        cfg_data,
  output logic signed [FB-1:0]                      view_min_x,
  output logic signed [FB-1:0]                      view_max_x,
  output logic signed [FB-1:0]                      view_min_y,
  output logic signed [FB-1:0]                      view_max_y,
  output logic [SZB-1:0]                            image_width,
  output logic [SZB-1:0]                            image_height,
  output logic [mbe_pkg::LIMIT_BITS-1:0]            iteration_limit
);

  localparam int FRAC = FB - 4;
  localparam int SB   = CB + 1;

  logic [SZB-1:0] size_wr;

  // Size registers keep only the pixel-size bits of a write
  assign size_wr = SZB'(cfg_data[SB-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      view_min_x      <= {4'b1110, {FRAC{1'b0}}};
      view_max_x      <= {4'b0001, {FRAC{1'b0}}};
      view_min_y      <= {4'b1111, {FRAC{1'b0}}};
      view_max_y      <= {4'b0001, {FRAC{1'b0}}};
      image_width     <= SZB'(mbe_pkg::SIZE_RESET);
      image_height    <= SZB'(mbe_pkg::SIZE_RESET);
      iteration_limit <= mbe_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mbe_pkg::REG_VIEW_MIN_X:      view_min_x      <= cfg_data;
        mbe_pkg::REG_VIEW_MAX_X:      view_max_x      <= cfg_data;
        mbe_pkg::REG_VIEW_MIN_Y:      view_min_y      <= cfg_data;
        mbe_pkg::REG_VIEW_MAX_Y:      view_max_y      <= cfg_data;
        mbe_pkg::REG_IMAGE_WIDTH:     image_width     <= size_wr;
        mbe_pkg::REG_IMAGE_HEIGHT:    image_height    <= size_wr;
        mbe_pkg::REG_ITERATION_LIMIT: iteration_limit <= cfg_data[mbe_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mbe_ctrl.sv -----
`default_nettype none

module mbe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pixel_valid,
  output logic               pixel_stall,
  output logic               count_valid,
  input  wire logic          count_stall,
  output mbe_pkg::cmd_t      cmd,
  input  wire mbe_pkg::sts_t sts
);

  mbe_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !count_valid || !count_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mbe_pkg::ST_IDLE;
      count_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        count_valid <= 1'b1;
      end else if (!count_stall) begin
        count_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mbe_pkg::ST_IDLE:    if (pixel_valid) state_next = mbe_pkg::ST_DIV;
      mbe_pkg::ST_DIV:     if (sts.div_last) state_next = mbe_pkg::ST_MAP_MUL;
      mbe_pkg::ST_MAP_MUL: state_next = mbe_pkg::ST_MAP_FIN;
      mbe_pkg::ST_MAP_FIN: begin
        state_next = sts.limit_zero ? mbe_pkg::ST_FINISH : mbe_pkg::ST_IT_MUL;
      end
      mbe_pkg::ST_IT_MUL:  state_next = mbe_pkg::ST_IT_UPD;
      mbe_pkg::ST_IT_UPD: begin
        state_next = (sts.escape || sts.at_limit) ? mbe_pkg::ST_FINISH : mbe_pkg::ST_IT_MUL;
      end
      mbe_pkg::ST_FINISH:  if (out_free) state_next = mbe_pkg::ST_IDLE;
      default:             state_next = mbe_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    pixel_stall = 1'b1;
    case (state)
      mbe_pkg::ST_IDLE: begin
        pixel_stall = 1'b0;
        cmd.load    = pixel_valid;
      end
      mbe_pkg::ST_DIV:     cmd.div_step = 1'b1;
      mbe_pkg::ST_MAP_MUL: begin
        cmd.mul     = 1'b1;
        cmd.map_sel = 1'b1;
      end
      mbe_pkg::ST_MAP_FIN: cmd.map_fin = 1'b1;
      mbe_pkg::ST_IT_MUL:  cmd.mul     = 1'b1;
      mbe_pkg::ST_IT_UPD:  cmd.iter    = 1'b1;
      mbe_pkg::ST_FINISH:  cmd.publish = out_free;
      default: ;
    endcase
  end

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(count_valid) |-> $past(state == mbe_pkg::ST_FINISH))
    else $error("result shown without finishing a request");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    count_valid && !count_stall && state != mbe_pkg::ST_FINISH |=> !count_valid)
    else $error("taken result not dropped");

endmodule

`default_nettype wire

// ----- rtl/mbe_dpath.sv -----
`default_nettype none

module mbe_dpath #(
  parameter int CB  = 12,
  parameter int FB  = 32,
  parameter int NB  = 16,
  parameter int SZB = 13
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [CB-1:0]                    pixel_x,
  input  wire logic [CB-1:0]                    pixel_y,
  input  wire logic signed [FB-1:0]             view_min_x,
  input  wire logic signed [FB-1:0]             view_max_x,
  input  wire logic signed [FB-1:0]             view_min_y,
  input  wire logic signed [FB-1:0]             view_max_y,
  input  wire logic [SZB-1:0]                   image_width,
  input  wire logic [SZB-1:0]                   image_height,
  input  wire logic [mbe_pkg::LIMIT_BITS-1:0]   iteration_limit,
  input  wire mbe_pkg::cmd_t                    cmd,
  output mbe_pkg::sts_t                         sts,
  output logic [NB-1:0]                         escape_count
);

  localparam int FRAC = FB - 4;
  localparam int QB   = CB + FRAC;
  localparam int PB   = 2 * FB;
  localparam int DCB  = $clog2(QB);
  localparam int LB   = (NB > mbe_pkg::LIMIT_BITS) ? NB : mbe_pkg::LIMIT_BITS;
  localparam logic signed [FB-1:0] MAXV = {1'b0, {(FB-1){1'b1}}};
  localparam logic signed [FB-1:0] MINV = {1'b1, {(FB-1){1'b0}}};
  localparam logic signed [FB-1:0] FOUR = {2'b01, {(FB-2){1'b0}}};

  function automatic logic signed [FB-1:0] sat_add(input logic signed [FB-1:0] a,
                                                   input logic signed [FB-1:0] b);
    logic signed [FB:0] s;
    s = {a[FB-1], a} + {b[FB-1], b};
    if (s[FB] != s[FB-1]) return s[FB] ? MINV : MAXV;
    return s[FB-1:0];
  endfunction

  function automatic logic signed [FB-1:0] sat_sub(input logic signed [FB-1:0] a,
                                                   input logic signed [FB-1:0] b);
    logic signed [FB:0] s;
    s = {a[FB-1], a} - {b[FB-1], b};
    if (s[FB] != s[FB-1]) return s[FB] ? MINV : MAXV;
    return s[FB-1:0];
  endfunction

  // Floor a full product to the fraction width, saturate to the word range
  function automatic logic signed [FB-1:0] fsat(input logic signed [PB-1:0] p);
    logic [PB-FB-FRAC:0] top;
    top = p[PB-1:FB-1+FRAC];
    if ((&top) || !(|top)) return p[FRAC+FB-1:FRAC];
    return p[PB-1] ? MINV : MAXV;
  endfunction

  // Divider lanes: 0 = x, 1 = y
  logic [QB-1:0]             quo   [2];
  logic [SZB-1:0]            rem   [2];
  logic [SZB-1:0]            dsr   [2];
  logic [SZB:0]              trial [2];
  logic [SZB:0]              rsub  [2];
  logic [1:0]                ge;
  logic [DCB-1:0]            div_cnt;
  logic signed [FB-1:0]      ratio [2];
  logic signed [FB-1:0]      diff  [2];
  logic signed [FB-1:0]      lo    [2];

  logic signed [FB-1:0]      op_a0, op_a1, op_b0, op_b1;
  logic signed [PB-1:0]      prod_a, prod_b, prod_c;
  logic signed [FB-1:0]      cx, cy, zr, zi;
  logic signed [FB-1:0]      zr2, zi2, cr, mag, zr_next, zi_next;
  logic [NB-1:0]             count, count_inc, lim_eff;
  logic [LB-1:0]             lim_wide;

  always_comb begin
    dsr[0]  = (image_width == '0) ? SZB'(1) : image_width;
    dsr[1]  = (image_height == '0) ? SZB'(1) : image_height;
    lo[0]   = view_min_x;
    lo[1]   = view_min_y;
    diff[0] = sat_sub(view_max_x, view_min_x);
    diff[1] = sat_sub(view_max_y, view_min_y);
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem[i], quo[i][QB-1]};
      rsub[i]  = trial[i] - {1'b0, dsr[i]};
      ge[i]    = trial[i] >= {1'b0, dsr[i]};
      // Quotient of eight or more saturates
      ratio[i] = (|quo[i][QB-1:FB-1]) ? MAXV : {1'b0, quo[i][FB-2:0]};
    end
  end

  always_comb begin
    op_a0 = cmd.map_sel ? ratio[0] : zr;
    op_a1 = cmd.map_sel ? diff[0]  : zr;
    op_b0 = cmd.map_sel ? ratio[1] : zi;
    op_b1 = cmd.map_sel ? diff[1]  : zi;
  end

  always_comb begin
    zr2       = fsat(prod_a);
    zi2       = fsat(prod_b);
    cr        = fsat(prod_c);
    mag       = sat_add(zr2, zi2);
    zr_next   = sat_add(sat_sub(zr2, zi2), cx);
    zi_next   = sat_add(sat_add(cr, cr), cy);
    count_inc = count + 1'b1;
    lim_wide  = LB'(iteration_limit);
    lim_eff   = (lim_wide > LB'({NB{1'b1}})) ? {NB{1'b1}} : lim_wide[NB-1:0];
  end

  always_comb begin
    sts.div_last   = (div_cnt == DCB'(QB - 1));
    sts.limit_zero = (lim_eff == '0);
    sts.escape     = (mag > FOUR);
    sts.at_limit   = (count_inc == lim_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo[0]  <= {pixel_x, {FRAC{1'b0}}};
      quo[1]  <= {pixel_y, {FRAC{1'b0}}};
      rem[0]  <= '0;
      rem[1]  <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      for (int i = 0; i < 2; i++) begin
        rem[i] <= ge[i] ? rsub[i][SZB-1:0] : trial[i][SZB-1:0];
        quo[i] <= {quo[i][QB-2:0], ge[i]};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.mul) begin
      prod_a <= PB'(op_a0) * PB'(op_a1);
      prod_b <= PB'(op_b0) * PB'(op_b1);
      prod_c <= PB'(zr) * PB'(zi);
    end
    if (cmd.map_fin) begin
      cx    <= sat_add(fsat(prod_a), lo[0]);
      cy    <= sat_add(fsat(prod_b), lo[1]);
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (cmd.iter && !sts.escape) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= count_inc;
    end
    if (cmd.publish) begin
      escape_count <= count;
    end
  end

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem[0] < dsr[0] && rem[1] < dsr[1])
    else $error("divider remainder not below divisor");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.iter && !sts.escape |=> count == $past(count) + 1'b1)
    else $error("iteration count did not advance");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> escape_count <= lim_eff)
    else $error("escape count above iteration limit");

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time.sv -----
// Escape-time evaluator: one pixel request in, one iteration count out.
// Pixel channel: pixel_valid/pixel_stall with pixel_x, pixel_y. A request is
// taken at an edge with pixel_valid high and pixel_stall low; pixel_stall is
// low only while the block is idle.
// Result channel: count_valid/count_stall with escape_count, held in an
// output register, so the next request is taken while a result still waits.
// Configuration: cfg_write, cfg_index, cfg_data write one viewport, size or
// limit register per edge; write only while no request is in flight.
// From acceptance to count_valid, a request passes the bit-serial divider,
// which forms pixel/size with QB = COORD_BITS + FIXED_BITS - 4 quotient bits
// (40 by default), the mapping, then k z^2 + c steps, where k is the number
// of steps evaluated (the count, plus one when the point escapes). Each step
// registers the three multiplies, then applies the saturating update.
// A new request can be taken in the cycle after the result is loaded.
// Reset (synchronous, rst high) returns to idle, drops count_valid and loads
// the default viewport -2..1 by -1..1, 1024x1024 pixels, limit 256.
// A stalled result holds; the block finishes its next request and waits
// until the output register is free before loading it.

`default_nettype none

module mandelbrot_escape_time #(
  parameter int COORD_BITS = 12,
  parameter int FIXED_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               pixel_valid,
  output logic                                    pixel_stall,
  input  wire logic [COORD_BITS-1:0]              pixel_x,
  input  wire logic [COORD_BITS-1:0]              pixel_y,
  output logic                                    count_valid,
  input  wire logic                               count_stall,
  output logic [COUNT_BITS-1:0]                   escape_count,
  input  wire logic                               cfg_write,
  input  wire logic [mbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [FIXED_BITS-1:0]              cfg_data
);

  // Size registers must also hold the 1024 reset value at narrow pixel widths
  localparam int SZB = (COORD_BITS + 1 > mbe_pkg::SIZE_RESET_BITS) ?
                       COORD_BITS + 1 : mbe_pkg::SIZE_RESET_BITS;

  logic signed [FIXED_BITS-1:0]       view_min_x, view_max_x;
  logic signed [FIXED_BITS-1:0]       view_min_y, view_max_y;
  logic [SZB-1:0]                     image_width, image_height;
  logic [mbe_pkg::LIMIT_BITS-1:0]     iteration_limit;
  mbe_pkg::cmd_t                      cmd;
  mbe_pkg::sts_t                      sts;

  // Configuration register file
  mbe_regs #(
    .CB  (COORD_BITS),
    .FB  (FIXED_BITS),
    .SZB (SZB)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .view_min_x      (view_min_x),
    .view_max_x      (view_max_x),
    .view_min_y      (view_min_y),
    .view_max_y      (view_max_y),
    .image_width     (image_width),
    .image_height    (image_height),
    .iteration_limit (iteration_limit)
  );

  // Sequencer: divide, map, iterate, publish
  mbe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .count_valid (count_valid),
    .count_stall (count_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Divider lanes, shared multipliers, z registers and result register
  mbe_dpath #(
    .CB  (COORD_BITS),
    .FB  (FIXED_BITS),
    .NB  (COUNT_BITS),
    .SZB (SZB)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .view_min_x      (view_min_x),
    .view_max_x      (view_max_x),
    .view_min_y      (view_min_y),
    .view_max_y      (view_max_y),
    .image_width     (image_width),
    .image_height    (image_height),
    .iteration_limit (iteration_limit),
    .cmd             (cmd),
    .sts             (sts),
    .escape_count    (escape_count)
  );

endmodule

`default_nettype wire
